// ===== src/swmm_pkg.sv =====
// shared widths, field positions and reset values for the sliding window block
`timescale 1ns / 1ps
package swmm_pkg;

  // field widths
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned MAX_FIELD_W  = 31;
  localparam int unsigned CNT_W        = 9;
  localparam int unsigned IN_TDATA_W   = 32;
  localparam int unsigned OUT_TDATA_W  = 104;

  // field positions in the output word
  localparam int unsigned OUT_NEWEST_LSB = 0;
  localparam int unsigned OUT_MEAN_LSB   = 32;
  localparam int unsigned OUT_MAX_LSB    = 64;
  localparam int unsigned OUT_CNT_LSB    = 95;

  // defaults
  localparam int unsigned MAX_WINDOW_DEF = 256;
  localparam logic [CNT_W-1:0] WINDOW_RESET = 9'd10;

endpackage

// ===== src/sliding_window_mean_max_top.sv =====
// sliding window of signed samples with running mean and floored maximum
//
// Input: one 32-bit signed sample a word on the s_axis channel. Output: one
// result word on the m_axis channel for every sample, holding the sample, the
// mean of the held samples (truncated toward zero), the largest held sample
// floored at zero, and the number of samples held.
// The window size register is written through the cfg channel while the
// block is idle; every write empties the ring. Zero acts as one, and values
// above MAX_WINDOW act as MAX_WINDOW.
// Each sample passes the update, load and run states; the run state ends
// when both the bit-serial divider and the maximum scan, which reads the
// sample memory one entry a cycle, are done; both run side by side. One
// sample is in work at a time; the next one is taken once the result sits
// in the output register, even if the receiver has not yet taken it.
// Reset: window size 10, empty ring, no result pending. The sample memory
// is not cleared; only entries written since the last emptying are read.
// A stalled receiver holds the result word; the block then waits with the
// next result until the output register is free.
`timescale 1ns / 1ps
module sliding_window_mean_max_top import swmm_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CNT_W-1:0]       cfg_data_i,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] sample
  // output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [31:0] newest_sample, [63:32] window_mean,
                                                 // [94:64] window_max, [103:95] held_count
);

  localparam int unsigned AW  = $clog2(MAX_WINDOW);
  localparam int unsigned CW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned TW  = DATA_W + CW;
  localparam int unsigned DCW = $clog2(TW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_LOAD,
    S_RUN,
    S_OUT
  } state_e;

  state_e                   state_q;
  logic [CNT_W-1:0]         window_q;
  logic [AW-1:0]            slot_q;
  logic [CW-1:0]            fill_q;
  logic signed [TW-1:0]     total_q;
  logic signed [DATA_W-1:0] sample_q;

  // divider and scan state
  logic [TW-1:0]            quo_q;
  logic [CW-1:0]            rem_q;
  logic [DCW-1:0]           div_cnt_q;
  logic                     neg_q;
  logic [CW-1:0]            scan_q;
  logic                     rd_vld_q;
  logic signed [DATA_W-1:0] max_q;

  // output register
  logic                     m_valid_q;
  logic [OUT_TDATA_W-1:0]   m_data_q;

  // sample memory
  logic signed [DATA_W-1:0] ring_mem [MAX_WINDOW];
  logic signed [DATA_W-1:0] mem_rdata_q;
  logic                     mem_we;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;

  logic                     s_acc;
  logic [CW-1:0]            win;
  logic [AW-1:0]            slot_eff;
  logic [CW-1:0]            slot_inc;
  logic [AW-1:0]            slot_nxt;
  logic                     full;
  logic signed [TW-1:0]     old_ext;
  logic signed [TW-1:0]     total_d;
  logic [TW-1:0]            total_mag;
  logic [CW:0]              div_sh;
  logic [CW:0]              div_sub;
  logic                     div_ge;
  logic                     div_done;
  logic                     scan_more;
  logic                     scan_done;
  logic [DATA_W-1:0]        mean_res;
  logic                     out_load;

  assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // result enters the output register when it is free or being taken
  assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

  // effective window: zero acts as one, large values saturate
  always_comb begin
    if (window_q == '0) begin
      win = CW'(1);
    end else if (32'(window_q) > MAX_WINDOW) begin
      win = CW'(MAX_WINDOW);
    end else begin
      win = CW'(window_q);
    end
  end

  // ring slot handling
  assign slot_eff = (CW'(slot_q) >= win) ? '0 : slot_q;
  assign slot_inc = CW'(slot_q) + CW'(1);
  assign slot_nxt = (slot_inc >= win) ? '0 : slot_inc[AW-1:0];
  assign full     = (fill_q >= win);

  // running total update, oldest sample leaves once the ring is full
  assign old_ext  = full ? TW'(mem_rdata_q) : '0;
  assign total_d  = total_q - old_ext + TW'(sample_q);
  assign total_mag = total_q[TW-1] ? TW'(-total_q) : TW'(total_q);

  // one restoring division step a cycle
  assign div_sh   = {rem_q, quo_q[TW-1]};
  assign div_ge   = (div_sh >= {1'b0, fill_q});
  assign div_sub  = div_sh - {1'b0, fill_q};
  assign div_done = (div_cnt_q == '0);
  assign mean_res = neg_q ? (DATA_W'(0) - quo_q[DATA_W-1:0]) : quo_q[DATA_W-1:0];

  // maximum scan over the written entries
  assign scan_more = (scan_q < fill_q);
  assign scan_done = !scan_more && !rd_vld_q;

  // memory port control
  assign mem_we    = (state_q == S_UPD);
  assign mem_re    = ((state_q == S_IDLE) && s_acc) || ((state_q == S_RUN) && scan_more);
  assign mem_raddr = (state_q == S_IDLE) ? slot_eff : scan_q[AW-1:0];

  // sample memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[slot_q] <= sample_q;
    end
    if (mem_re) begin
      mem_rdata_q <= ring_mem[mem_raddr];
    end
  end

  // sequencer, window state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      window_q  <= WINDOW_RESET;
      slot_q    <= '0;
      fill_q    <= '0;
      total_q   <= '0;
      div_cnt_q <= '0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
      sample_q  <= '0;
      quo_q     <= '0;
      rem_q     <= '0;
      neg_q     <= 1'b0;
      scan_q    <= '0;
      max_q     <= '0;
      m_data_q  <= '0;
    end else begin
      // output word loaded or taken
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) begin
            window_q <= cfg_data_i;
            slot_q   <= '0;
            fill_q   <= '0;
            total_q  <= '0;
          end else if (s_acc) begin
            sample_q <= s_axis_tdata;
            slot_q   <= slot_eff;
            state_q  <= S_UPD;
          end
        end
        S_UPD: begin
          total_q <= total_d;
          if (!full) begin
            fill_q <= fill_q + CW'(1);
          end
          slot_q  <= slot_nxt;
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          neg_q     <= total_q[TW-1];
          quo_q     <= total_mag;
          rem_q     <= '0;
          div_cnt_q <= DCW'(TW);
          scan_q    <= '0;
          rd_vld_q  <= 1'b0;
          max_q     <= '0;
          state_q   <= S_RUN;
        end
        S_RUN: begin
          if (!div_done) begin
            rem_q     <= div_ge ? div_sub[CW-1:0] : div_sh[CW-1:0];
            quo_q     <= {quo_q[TW-2:0], div_ge};
            div_cnt_q <= div_cnt_q - DCW'(1);
          end
          if (scan_more) begin
            scan_q <= scan_q + CW'(1);
          end
          rd_vld_q <= scan_more;
          if (rd_vld_q && (mem_rdata_q > max_q)) begin
            max_q <= mem_rdata_q;
          end
          if (div_done && scan_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            m_data_q  <= {CNT_W'(fill_q), max_q[MAX_FIELD_W-1:0], mean_res, sample_q};
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/swmm_checker.sv =====
// port-level checks for the sliding window block, bound to the top level
`timescale 1ns / 1ps
module swmm_checker import swmm_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // every result follows a push, so at least one sample is held
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_CNT_LSB +: CNT_W] != '0)
    else $error("result with no held samples");

  // held count never exceeds the ring depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(m_axis_tdata[OUT_CNT_LSB +: CNT_W]) <= MAX_WINDOW)
    else $error("held count beyond ring depth");

  // one sample in work at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second sample taken while one is in work");

endmodule

bind sliding_window_mean_max_top swmm_checker #(
  .MAX_WINDOW (MAX_WINDOW)
) u_swmm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
